### sv/kd2i_pkg.sv
// Shared types and constants of the 2-d tree insertion block.
package kd2i_pkg;

  localparam int unsigned IN_W       = 32;
  localparam int unsigned SLOT_OUT_W = 10;
  localparam int unsigned Z_OUT_W    = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_LINK
  } state_e;

  typedef struct packed {
    logic acc_full;
    logic acc_root;
    logic acc_walk;
    logic walk_step;
    logic walk_end;
    logic link_write;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic brk;
  } status_t;

endpackage

### sv/kd_tree_2d_insert.sv
// Top level of the 2-d tree insertion block.
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+----------------------------
//  point in | px_i, py_i, pz_i                              | taken when start & !busy
//  result   | stored_slot_o, parent_slot_o, went_left_o,    | done_o high for one cycle,
//           | is_root_o, table_full_o, lowest_z_o,          | no back-pressure
//           | highest_z_o                                   |
//
// A point that lands at tree depth d passes from start to the next possible start through
// the accept step, one walk step per visited node (one node memory read per level) and
// the write of the parent's link. The root and a dropped point need the accept step only.
// The result word appears the cycle after the last step.
// Reset empties the tree and clears the z range; node memories need no clearing.
// The receiver cannot stall, so the result word is shown exactly once.
module kd_tree_2d_insert #(
  parameter int unsigned NODE_CAPACITY = 1024,
  parameter int unsigned COORD_BITS    = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [kd2i_pkg::IN_W-1:0]     px_i,
  input  logic signed [kd2i_pkg::IN_W-1:0]     py_i,
  input  logic signed [kd2i_pkg::IN_W-1:0]     pz_i,
  output logic                                 done_o,
  output logic [kd2i_pkg::SLOT_OUT_W-1:0]      stored_slot_o,
  output logic [kd2i_pkg::SLOT_OUT_W-1:0]      parent_slot_o,
  output logic                                 went_left_o,
  output logic                                 is_root_o,
  output logic                                 table_full_o,
  output logic signed [kd2i_pkg::Z_OUT_W-1:0]  lowest_z_o,
  output logic signed [kd2i_pkg::Z_OUT_W-1:0]  highest_z_o
);
  import kd2i_pkg::*;

  cmd_t                 cmd;
  status_t              status;
  logic [Z_OUT_W-1:0]   lowest_z, highest_z;

  kd2i_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  kd2i_dp #(
    .NODE_CAPACITY (NODE_CAPACITY),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .px_i          (px_i),
    .py_i          (py_i),
    .pz_i          (pz_i),
    .done_o        (done_o),
    .stored_slot_o (stored_slot_o),
    .parent_slot_o (parent_slot_o),
    .went_left_o   (went_left_o),
    .is_root_o     (is_root_o),
    .table_full_o  (table_full_o),
    .lowest_z_o    (lowest_z),
    .highest_z_o   (highest_z)
  );

  assign lowest_z_o  = signed'(lowest_z);
  assign highest_z_o = signed'(highest_z);

endmodule

### sv/kd2i_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module kd2i_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/kd2i_ctrl.sv
// Controller state machine of the 2-d tree insertion block.
module kd2i_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  kd2i_pkg::status_t status_i,
  output logic              busy,
  output kd2i_pkg::cmd_t    cmd_o
);
  import kd2i_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start && !status_i.full && !status_i.empty) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status_i.brk) begin
          state_d = ST_LINK;
        end
      end
      ST_LINK: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy           = 1'b0;
        cmd_o.acc_full = start && status_i.full;
        cmd_o.acc_root = start && !status_i.full && status_i.empty;
        cmd_o.acc_walk = start && !status_i.full && !status_i.empty;
      end
      ST_WALK: begin
        cmd_o.walk_step = !status_i.brk;
        cmd_o.walk_end  = status_i.brk;
      end
      ST_LINK: begin
        cmd_o.link_write = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

### sv/kd2i_dp.sv
// Datapath of the 2-d tree insertion block: node memories, walk registers, z range.
module kd2i_dp #(
  parameter int unsigned NODE_CAPACITY = 1024,
  parameter int unsigned COORD_BITS    = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kd2i_pkg::cmd_t                      cmd_i,
  output kd2i_pkg::status_t                   status_o,
  input  logic [kd2i_pkg::IN_W-1:0]           px_i,
  input  logic [kd2i_pkg::IN_W-1:0]           py_i,
  input  logic [kd2i_pkg::IN_W-1:0]           pz_i,
  output logic                                done_o,
  output logic [kd2i_pkg::SLOT_OUT_W-1:0]     stored_slot_o,
  output logic [kd2i_pkg::SLOT_OUT_W-1:0]     parent_slot_o,
  output logic                                went_left_o,
  output logic                                is_root_o,
  output logic                                table_full_o,
  output logic [kd2i_pkg::Z_OUT_W-1:0]        lowest_z_o,
  output logic [kd2i_pkg::Z_OUT_W-1:0]        highest_z_o
);
  import kd2i_pkg::*;

  localparam int unsigned SLOT_W = $clog2(NODE_CAPACITY);
  localparam int unsigned CNT_W  = $clog2(NODE_CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(NODE_CAPACITY);
  localparam logic [COORD_BITS-1:0] SIGN_C = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Input words are zero-extended or truncated to the coordinate width.
  logic [COORD_BITS+IN_W-1:0] px_ext, py_ext, pz_ext;
  logic [COORD_BITS-1:0]      px_c, py_c, pz_c;

  assign px_ext = {{COORD_BITS{1'b0}}, px_i};
  assign py_ext = {{COORD_BITS{1'b0}}, py_i};
  assign pz_ext = {{COORD_BITS{1'b0}}, pz_i};
  assign px_c   = px_ext[COORD_BITS-1:0];
  assign py_c   = py_ext[COORD_BITS-1:0];
  assign pz_c   = pz_ext[COORD_BITS-1:0];

  logic [COORD_BITS-1:0] x_q, y_q, min_q, max_q, min_d, max_d;
  logic [SLOT_W-1:0]     idx_q;
  logic                  xdim_q, left_q;
  logic [CNT_W-1:0]      count_q, guard_q;
  logic [SLOT_W-1:0]     pos;

  assign pos = count_q[SLOT_W-1:0];

  // Node memories.
  logic                    coord_we, lnk_l_we, lnk_r_we;
  logic [SLOT_W-1:0]       coord_waddr, lnk_waddr, raddr;
  logic [2*COORD_BITS-1:0] coord_wdata, coord_rdata;
  logic [SLOT_W-1:0]       lnk_wdata, lnk_l_rdata, lnk_r_rdata;

  kd2i_ram #(.WIDTH(2*COORD_BITS), .DEPTH(NODE_CAPACITY)) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (coord_we),
    .waddr_i (coord_waddr),
    .wdata_i (coord_wdata),
    .raddr_i (raddr),
    .rdata_o (coord_rdata)
  );

  kd2i_ram #(.WIDTH(SLOT_W), .DEPTH(NODE_CAPACITY)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_l_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .raddr_i (raddr),
    .rdata_o (lnk_l_rdata)
  );

  kd2i_ram #(.WIDTH(SLOT_W), .DEPTH(NODE_CAPACITY)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_r_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .raddr_i (raddr),
    .rdata_o (lnk_r_rdata)
  );

  // Walk decision on the node that was read in the previous cycle.
  logic [COORD_BITS-1:0] node_x, node_y;
  logic                  go_left;
  logic [SLOT_W-1:0]     son;

  assign node_x  = coord_rdata[2*COORD_BITS-1:COORD_BITS];
  assign node_y  = coord_rdata[COORD_BITS-1:0];
  assign go_left = xdim_q ? ((x_q ^ SIGN_C) < (node_x ^ SIGN_C))
                          : ((y_q ^ SIGN_C) < (node_y ^ SIGN_C));
  assign son     = go_left ? lnk_l_rdata : lnk_r_rdata;

  assign status_o.full  = (count_q >= CAP_C);
  assign status_o.empty = (count_q == '0);
  assign status_o.brk   = (son == '0) || ({{CNT_W{1'b0}}, son} >= {{SLOT_W{1'b0}}, count_q})
                          || (guard_q >= count_q);

  assign raddr = cmd_i.walk_step ? son : '0;

  // The new node and its cleared links are written when the walk ends; the
  // parent's link follows in the next cycle.
  always_comb begin
    coord_we    = cmd_i.acc_root || cmd_i.walk_end;
    coord_waddr = cmd_i.acc_root ? '0 : pos;
    coord_wdata = cmd_i.acc_root ? {px_c, py_c} : {x_q, y_q};
    lnk_l_we    = cmd_i.acc_root || cmd_i.walk_end || (cmd_i.link_write && left_q);
    lnk_r_we    = cmd_i.acc_root || cmd_i.walk_end || (cmd_i.link_write && !left_q);
    lnk_waddr   = cmd_i.link_write ? idx_q : (cmd_i.acc_root ? '0 : pos);
    lnk_wdata   = cmd_i.link_write ? pos : '0;
  end

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (cmd_i.acc_root) begin
      min_d = pz_c;
      max_d = pz_c;
    end else if (cmd_i.acc_walk) begin
      if ((pz_c ^ SIGN_C) < (min_q ^ SIGN_C)) begin
        min_d = pz_c;
      end
      if ((pz_c ^ SIGN_C) > (max_q ^ SIGN_C)) begin
        max_d = pz_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      min_q   <= '0;
      max_q   <= '0;
      done_o  <= 1'b0;
    end else begin
      min_q  <= min_d;
      max_q  <= max_d;
      done_o <= cmd_i.acc_full || cmd_i.acc_root || cmd_i.link_write;
      if (cmd_i.acc_root || cmd_i.link_write) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_walk) begin
      x_q     <= px_c;
      y_q     <= py_c;
      idx_q   <= '0;
      xdim_q  <= 1'b1;
      guard_q <= '0;
    end else if (cmd_i.walk_step) begin
      idx_q   <= son;
      xdim_q  <= !xdim_q;
      guard_q <= guard_q + CNT_W'(1);
    end
    if (cmd_i.walk_end) begin
      left_q <= go_left;
    end
  end

  // Result registers; slot numbers are masked or extended to the port width.
  logic [SLOT_W+SLOT_OUT_W-1:0] pos_ext, idx_ext;
  logic [COORD_BITS+Z_OUT_W-1:0] min_ext, max_ext;

  assign pos_ext = {{SLOT_OUT_W{1'b0}}, pos};
  assign idx_ext = {{SLOT_OUT_W{1'b0}}, idx_q};
  assign min_ext = {{Z_OUT_W{1'b0}}, min_d};
  assign max_ext = {{Z_OUT_W{1'b0}}, max_d};

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_full || cmd_i.acc_root || cmd_i.link_write) begin
      stored_slot_o <= cmd_i.link_write ? pos_ext[SLOT_OUT_W-1:0] : '0;
      parent_slot_o <= cmd_i.link_write ? idx_ext[SLOT_OUT_W-1:0] : '0;
      went_left_o   <= cmd_i.link_write && left_q;
      is_root_o     <= cmd_i.acc_root;
      table_full_o  <= cmd_i.acc_full;
      lowest_z_o    <= min_ext[Z_OUT_W-1:0];
      highest_z_o   <= max_ext[Z_OUT_W-1:0];
    end
  end

endmodule
